// ===== hw/rtl/fdbh_pkg.sv =====
// Shared types, codes and constants for the frame dirty-box hash tracker.
// Used by the tracker, its checkers and its testbench; depends on nothing.
`default_nettype none

package fdbh_pkg;

   // FNV-1a constants (32-bit).
   localparam logic [31:0] HASH_OFFSET = 32'd2166136261;
   localparam logic [31:0] HASH_PRIME  = 32'd16777619;

   // Request operation codes.
   localparam logic OP_PIXEL  = 1'b0;
   localparam logic OP_FORGET = 1'b1;

   // Configuration register port and register indexes.
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_PAIRS  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 4'd1;

   // Field widths.
   localparam int WORD_W   = 32;
   localparam int BOX_XY_W = 8;
   localparam int BOX_WH_W = 9;

   // Result queue geometry.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_AW    = 2;
   localparam int RSP_CW    = 3;

   typedef struct packed {
      logic [BOX_XY_W-1:0] x;
      logic [BOX_XY_W-1:0] y;
      logic [BOX_WH_W-1:0] w;
      logic [BOX_WH_W-1:0] h;
   } box_type;

   // One FNV-1a fold: xor in the word, multiply by the prime, keep 32 bits.
   function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [31:0] w);
      logic [31:0] mixed;
      mixed = h ^ w;
      return mixed * HASH_PRIME;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/frame_dirty_box_hash_tracker.sv =====
// Top level of the frame dirty-box hash tracker: input stage, hash stage,
// compare stage and result queue. Depends on fdbh_pkg.
`default_nettype none

// The block hashes a raster frame of 32-bit pixel-pair words and reports the
// bounding box of what changed since the previous frame. One transaction on
// the req_ channel carries either a pixel-pair word or a forget command; the
// block accepts one transaction per clock cycle while req_ready is high. Each
// word goes through two register stages: the first one folds the word into the
// running row hash and the column-pair hash (two constant 32-bit multiplies),
// the second compares finished hashes against those stored from the previous
// frame and updates the changed-row and changed-pair trackers. The frame's
// last word produces one rsp_ transaction; a box of all zeros means nothing
// changed. Until one whole frame has been seen, or after a forget, everything
// counts as changed. Results wait in a four-entry queue, and req_ready drops
// only when four frame results are outstanding, so with a consumer that keeps
// rsp_ready high the block never stalls. Write width_pairs and frame_height
// only while the block is idle; a write restarts the frame, and after a size
// change a forget is required. The hash stores need no clearing pass after
// reset, so the block is ready in the cycle after reset.
module frame_dirty_box_hash_tracker
   import fdbh_pkg::*;
#(
   parameter int MAX_DIM = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic                   req_op,
   input  wire logic [WORD_W-1:0]      req_pixel_pair,

   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [BOX_XY_W-1:0]    rsp_box_x,
   output      logic [BOX_XY_W-1:0]    rsp_box_y,
   output      logic [BOX_WH_W-1:0]    rsp_box_w,
   output      logic [BOX_WH_W-1:0]    rsp_box_h,

   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int PAIR_DEPTH = MAX_DIM / 2;
   localparam int ROW_AW     = $clog2(MAX_DIM);
   localparam int PAIR_AW    = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;

   // ---------------------------------------------------------------------
   // Configuration registers. Out-of-range values are clamped when used.
   // ---------------------------------------------------------------------
   logic [7:0] width_pairs_ff;
   logic [8:0] frame_height_ff;
   logic       csr_hit;

   assign csr_ready = 1'b1;
   assign csr_hit   = csr_valid && csr_ready &&
                      (csr_index == CSR_WIDTH_PAIRS || csr_index == CSR_FRAME_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_pairs_ff  <= 8'd128;
         frame_height_ff <= 9'd256;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_WIDTH_PAIRS) begin
            width_pairs_ff <= csr_data[7:0];
         end
         if (csr_index == CSR_FRAME_HEIGHT) begin
            frame_height_ff <= csr_data;
         end
      end
   end

   logic [15:0]        pairs_used;
   logic [15:0]        rows_used;
   logic [PAIR_AW-1:0] last_pair;
   logic [ROW_AW-1:0]  last_row;

   // A zero size counts as one; sizes above the store depth count as the depth.
   always_comb begin
      if (width_pairs_ff == 8'd0) begin
         pairs_used = 16'd1;
      end else if ({8'd0, width_pairs_ff} > 16'(PAIR_DEPTH)) begin
         pairs_used = 16'(PAIR_DEPTH);
      end else begin
         pairs_used = {8'd0, width_pairs_ff};
      end
      if (frame_height_ff == 9'd0) begin
         rows_used = 16'd1;
      end else if ({7'd0, frame_height_ff} > 16'(MAX_DIM)) begin
         rows_used = 16'(MAX_DIM);
      end else begin
         rows_used = {7'd0, frame_height_ff};
      end
      last_pair = PAIR_AW'(pairs_used - 16'd1);
      last_row  = ROW_AW'(rows_used - 16'd1);
   end

   // ---------------------------------------------------------------------
   // Input stage: raster position and flow control. The position counters
   // advance on the accepting edge, so every word knows its place at once.
   // ---------------------------------------------------------------------
   logic [PAIR_AW-1:0] pair_pos_ff;
   logic [ROW_AW-1:0]  row_pos_ff;
   logic [RSP_CW-1:0]  credit_ff;
   logic               accept;
   logic               acc_word;
   logic               acc_forget;
   logic               at_last_pair;
   logic               at_last_row;
   logic               acc_frame_end;
   logic               rsp_take;

   // The credit count holds frame-ending words accepted but not yet delivered;
   // it never exceeds the result queue depth, so the queue cannot overflow.
   assign req_ready     = (credit_ff != RSP_CW'(RSP_DEPTH));
   assign accept        = req_valid && req_ready;
   assign acc_word      = accept && (req_op == OP_PIXEL);
   assign acc_forget    = accept && (req_op == OP_FORGET);
   assign at_last_pair  = (pair_pos_ff == last_pair);
   assign at_last_row   = (row_pos_ff == last_row);
   assign acc_frame_end = acc_word && at_last_pair && at_last_row;
   assign rsp_take      = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_pos_ff <= '0;
         row_pos_ff  <= '0;
         credit_ff   <= '0;
      end else begin
         if (csr_hit || acc_forget) begin
            pair_pos_ff <= '0;
            row_pos_ff  <= '0;
         end else if (acc_word) begin
            if (at_last_pair) begin
               pair_pos_ff <= '0;
               row_pos_ff  <= at_last_row ? '0 : row_pos_ff + ROW_AW'(1);
            end else begin
               pair_pos_ff <= pair_pos_ff + PAIR_AW'(1);
            end
         end
         if (acc_frame_end && !rsp_take) begin
            credit_ff <= credit_ff + RSP_CW'(1);
         end else if (!acc_frame_end && rsp_take) begin
            credit_ff <= credit_ff - RSP_CW'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Hash stage registers, loaded on acceptance.
   // ---------------------------------------------------------------------
   logic               s1_valid_ff;
   logic               s1_forget_ff;
   logic [WORD_W-1:0]  s1_word_ff;
   logic [PAIR_AW-1:0] s1_x_ff;
   logic [ROW_AW-1:0]  s1_y_ff;
   logic               s1_first_row_ff;
   logic               s1_first_pair_ff;
   logic               s1_last_row_ff;
   logic               s1_last_pair_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_forget_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s1_forget_ff <= acc_forget;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff       <= req_pixel_pair;
         s1_x_ff          <= pair_pos_ff;
         s1_y_ff          <= row_pos_ff;
         s1_first_row_ff  <= (row_pos_ff == '0);
         s1_first_pair_ff <= (pair_pos_ff == '0);
         s1_last_row_ff   <= at_last_row;
         s1_last_pair_ff  <= at_last_pair;
      end
   end

   // ---------------------------------------------------------------------
   // Hash stores. Each is read on the accepting edge at the new word's
   // address and written from the hash stage. A write in the same cycle as a
   // read at the same address is caught by a bypass flag, and the new value
   // is then taken from the compare stage registers, which hold it.
   // ---------------------------------------------------------------------
   logic [31:0] run_pair_mem  [PAIR_DEPTH];
   logic [31:0] prev_pair_mem [PAIR_DEPTH];
   logic [31:0] prev_row_mem  [MAX_DIM];
   logic [31:0] run_pair_rd_ff;
   logic [31:0] prev_pair_rd_ff;
   logic [31:0] prev_row_rd_ff;
   logic        byp_run_pair_ff;
   logic        byp_prev_pair_ff;
   logic        byp_prev_row_ff;

   logic        s1_write;
   logic [31:0] pair_base_in;
   logic [31:0] pair_hash_in;
   logic [31:0] row_base_in;
   logic [31:0] row_hash_in;
   logic [31:0] prev_pair_in;
   logic [31:0] prev_row_in;
   logic        byp_run_pair_in;
   logic        byp_prev_pair_in;
   logic        byp_prev_row_in;

   // Compare stage registers (declared here for the bypass paths).
   logic               s2_valid_ff;
   logic               s2_forget_ff;
   logic [PAIR_AW-1:0] s2_x_ff;
   logic [ROW_AW-1:0]  s2_y_ff;
   logic               s2_last_row_ff;
   logic               s2_last_pair_ff;
   logic [31:0]        s2_pair_hash_ff;
   logic [31:0]        s2_prev_pair_ff;
   logic [31:0]        s2_prev_row_ff;
   logic [31:0]        row_hash_ff;

   assign s1_write = s1_valid_ff && !s1_forget_ff;

   always_comb begin
      // A column pair starts from the offset in row 0; a row starts from the
      // offset at its first pair.
      pair_base_in = s1_first_row_ff ? HASH_OFFSET :
                     (byp_run_pair_ff ? s2_pair_hash_ff : run_pair_rd_ff);
      pair_hash_in = fnv_step(pair_base_in, s1_word_ff);
      row_base_in  = s1_first_pair_ff ? HASH_OFFSET : row_hash_ff;
      row_hash_in  = fnv_step(row_base_in, s1_word_ff);
      prev_pair_in = byp_prev_pair_ff ? s2_pair_hash_ff : prev_pair_rd_ff;
      prev_row_in  = byp_prev_row_ff ? row_hash_ff : prev_row_rd_ff;

      byp_run_pair_in  = s1_write && (s1_x_ff == pair_pos_ff);
      byp_prev_pair_in = s1_write && s1_last_row_ff && (s1_x_ff == pair_pos_ff);
      byp_prev_row_in  = s1_write && s1_last_pair_ff && (s1_y_ff == row_pos_ff);
   end

   always_ff @(posedge clock) begin
      if (s1_write) begin
         run_pair_mem[s1_x_ff] <= pair_hash_in;
      end
      run_pair_rd_ff <= run_pair_mem[pair_pos_ff];
   end

   // The stored pair hashes are refreshed only in the frame's last row.
   always_ff @(posedge clock) begin
      if (s1_write && s1_last_row_ff) begin
         prev_pair_mem[s1_x_ff] <= pair_hash_in;
      end
      prev_pair_rd_ff <= prev_pair_mem[pair_pos_ff];
   end

   // A row hash is stored when the row's last pair has been folded in.
   always_ff @(posedge clock) begin
      if (s1_write && s1_last_pair_ff) begin
         prev_row_mem[s1_y_ff] <= row_hash_in;
      end
      prev_row_rd_ff <= prev_row_mem[row_pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_run_pair_ff  <= 1'b0;
         byp_prev_pair_ff <= 1'b0;
         byp_prev_row_ff  <= 1'b0;
      end else begin
         byp_run_pair_ff  <= byp_run_pair_in;
         byp_prev_pair_ff <= byp_prev_pair_in;
         byp_prev_row_ff  <= byp_prev_row_in;
      end
   end

   // ---------------------------------------------------------------------
   // Compare stage registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s2_forget_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s1_valid_ff;
         s2_forget_ff <= s1_valid_ff && s1_forget_ff;
      end
   end

   // The running row hash doubles as the compare stage's copy of it.
   always_ff @(posedge clock) begin
      if (s1_write) begin
         s2_x_ff         <= s1_x_ff;
         s2_y_ff         <= s1_y_ff;
         s2_last_row_ff  <= s1_last_row_ff;
         s2_last_pair_ff <= s1_last_pair_ff;
         s2_pair_hash_ff <= pair_hash_in;
         s2_prev_pair_ff <= prev_pair_in;
         s2_prev_row_ff  <= prev_row_in;
         row_hash_ff     <= row_hash_in;
      end
   end

   // ---------------------------------------------------------------------
   // Change trackers and frame result.
   // ---------------------------------------------------------------------
   logic               history_ff;
   logic [PAIR_AW-1:0] first_pair_ff;
   logic [PAIR_AW-1:0] last_pair_ff;
   logic               any_pair_ff;
   logic [ROW_AW-1:0]  first_row_ff;
   logic [ROW_AW-1:0]  last_row_ff;
   logic               any_row_ff;

   logic               s2_word;
   logic               s2_frame_end;
   logic               pair_diff;
   logic               row_diff;
   logic [PAIR_AW-1:0] first_pair_in;
   logic [PAIR_AW-1:0] last_pair_in;
   logic               any_pair_in;
   logic [ROW_AW-1:0]  first_row_in;
   logic [ROW_AW-1:0]  last_row_in;
   logic               any_row_in;
   logic [15:0]        left_px;
   logic [15:0]        width_px;
   logic [15:0]        top_row;
   logic [15:0]        height_rows;
   box_type            box_in;

   assign s2_word      = s2_valid_ff && !s2_forget_ff;
   assign s2_frame_end = s2_word && s2_last_pair_ff && s2_last_row_ff;

   always_comb begin
      // Without history every finished row and pair counts as changed.
      pair_diff = s2_last_row_ff &&
                  (!history_ff || (s2_pair_hash_ff != s2_prev_pair_ff));
      row_diff  = s2_last_pair_ff &&
                  (!history_ff || (row_hash_ff != s2_prev_row_ff));

      first_pair_in = (pair_diff && !any_pair_ff) ? s2_x_ff : first_pair_ff;
      last_pair_in  = pair_diff ? s2_x_ff : last_pair_ff;
      any_pair_in   = any_pair_ff || pair_diff;
      first_row_in  = (row_diff && !any_row_ff) ? s2_y_ff : first_row_ff;
      last_row_in   = row_diff ? s2_y_ff : last_row_ff;
      any_row_in    = any_row_ff || row_diff;

      // Pair indexes become pixel columns by doubling; fields wrap to width.
      left_px     = 16'(first_pair_in) << 1;
      width_px    = (16'(last_pair_in) - 16'(first_pair_in) + 16'd1) << 1;
      top_row     = 16'(first_row_in);
      height_rows = 16'(last_row_in) - 16'(first_row_in) + 16'd1;

      if (any_row_in && any_pair_in) begin
         box_in.x = left_px[BOX_XY_W-1:0];
         box_in.y = top_row[BOX_XY_W-1:0];
         box_in.w = width_px[BOX_WH_W-1:0];
         box_in.h = height_rows[BOX_WH_W-1:0];
      end else begin
         box_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff    <= 1'b0;
         first_pair_ff <= '0;
         last_pair_ff  <= '0;
         any_pair_ff   <= 1'b0;
         first_row_ff  <= '0;
         last_row_ff   <= '0;
         any_row_ff    <= 1'b0;
      end else if (csr_hit || (s2_valid_ff && s2_forget_ff) || s2_frame_end) begin
         // A register write keeps the history; a forget drops it; a finished
         // frame becomes the history for the next one.
         if (s2_valid_ff && s2_forget_ff) begin
            history_ff <= 1'b0;
         end else if (s2_frame_end) begin
            history_ff <= 1'b1;
         end
         first_pair_ff <= '0;
         last_pair_ff  <= '0;
         any_pair_ff   <= 1'b0;
         first_row_ff  <= '0;
         last_row_ff   <= '0;
         any_row_ff    <= 1'b0;
      end else if (s2_word) begin
         first_pair_ff <= first_pair_in;
         last_pair_ff  <= last_pair_in;
         any_pair_ff   <= any_pair_in;
         first_row_ff  <= first_row_in;
         last_row_ff   <= last_row_in;
         any_row_ff    <= any_row_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result queue. Frame results wait here until the consumer takes them.
   // ---------------------------------------------------------------------
   box_type           rsp_q_ff [RSP_DEPTH];
   logic [RSP_AW-1:0] wr_ptr_ff;
   logic [RSP_AW-1:0] rd_ptr_ff;
   logic [RSP_CW-1:0] fill_ff;
   box_type           rsp_head;

   always_ff @(posedge clock) begin
      if (s2_frame_end) begin
         rsp_q_ff[wr_ptr_ff] <= box_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (s2_frame_end) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_AW'(1);
         end
         if (rsp_take) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_AW'(1);
         end
         if (s2_frame_end && !rsp_take) begin
            fill_ff <= fill_ff + RSP_CW'(1);
         end else if (!s2_frame_end && rsp_take) begin
            fill_ff <= fill_ff - RSP_CW'(1);
         end
      end
   end

   assign rsp_head  = rsp_q_ff[rd_ptr_ff];
   assign rsp_valid = (fill_ff != '0);
   assign rsp_box_x = rsp_head.x;
   assign rsp_box_y = rsp_head.y;
   assign rsp_box_w = rsp_head.w;
   assign rsp_box_h = rsp_head.h;

endmodule

`default_nettype wire

// ===== hw/rtl/fdbh_checker.sv =====
// Port-level assertions for the frame dirty-box hash tracker, and the bind
// that attaches them to frame_dirty_box_hash_tracker. Depends on fdbh_pkg.
`default_nettype none

module fdbh_port_assertions
   import fdbh_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [BOX_XY_W-1:0]    rsp_box_x,
   input wire logic [BOX_XY_W-1:0]    rsp_box_y,
   input wire logic [BOX_WH_W-1:0]    rsp_box_w,
   input wire logic [BOX_WH_W-1:0]    rsp_box_h
);

   // Reset empties the result queue and frees all credit.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("result pending or input blocked after reset");

   // A waiting result transaction holds its box.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_box_x) &&
         $stable(rsp_box_y) && $stable(rsp_box_w) && $stable(rsp_box_h)))
      else $error("result changed while stalled");

   // An empty box is all zeros, and a non-empty box has a height.
   a_empty_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_box_w == '0) == (rsp_box_h == '0)) &&
         (rsp_box_w != '0 || (rsp_box_x == '0 && rsp_box_y == '0))))
      else $error("empty box with nonzero fields");

   // Boxes are built from pixel pairs, so left edge and width are even.
   a_even_columns: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_box_x[0] == 1'b0 && rsp_box_w[0] == 1'b0))
      else $error("box column or width is odd");

endmodule

bind frame_dirty_box_hash_tracker fdbh_port_assertions u_fdbh_port_assertions (.*);

`default_nettype wire

// ===== bench/fdbh_checker.sv =====
// Port checker for the frame dirty-box hash tracker: predicts every dirty box
// from the accepted request and register transactions and compares the results.
// Depends on fdbh_pkg for field widths, operation codes and register indexes.
`default_nettype none

module fdbh_checker
   import fdbh_pkg::*;
#(
   parameter int MAX_DIM = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire logic                   req_op,
   input  wire logic [WORD_W-1:0]      req_pixel_pair,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire logic [BOX_XY_W-1:0]    rsp_box_x,
   input  wire logic [BOX_XY_W-1:0]    rsp_box_y,
   input  wire logic [BOX_WH_W-1:0]    rsp_box_w,
   input  wire logic [BOX_WH_W-1:0]    rsp_box_h,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output int                          mismatch_count,
   output int                          boxes_pending,
   output int                          boxes_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAIR_DEPTH = MAX_DIM / 2;

   logic [7:0]        width_reg;
   logic [8:0]        height_reg;
   bit                seen_frame;
   logic [WORD_W-1:0] row_memory  [MAX_DIM];
   logic [WORD_W-1:0] pair_memory [PAIR_DEPTH];
   logic [WORD_W-1:0] col_acc     [PAIR_DEPTH];
   logic [WORD_W-1:0] row_acc;
   int unsigned       col_at, row_at;
   int unsigned       row_lo, row_hi, col_lo, col_hi;
   bit                row_dirty, col_dirty;
   box_type           expected_boxes [$];
   int                fail_total;
   int                checked_total;

   function automatic int unsigned pairs_in_row();
      int unsigned w;
      w = 32'(width_reg);
      if (w == 0) w = 1;
      if (w > PAIR_DEPTH) w = PAIR_DEPTH;
      return w;
   endfunction

   function automatic int unsigned rows_in_frame();
      int unsigned h;
      h = 32'(height_reg);
      if (h == 0) h = 1;
      if (h > MAX_DIM) h = MAX_DIM;
      return h;
   endfunction

   task automatic new_frame();
      row_acc   = HASH_OFFSET;
      col_at    = 0;
      row_at    = 0;
      row_lo    = 0;
      row_hi    = 0;
      row_dirty = 1'b0;
      col_lo    = 0;
      col_hi    = 0;
      col_dirty = 1'b0;
   endtask

   // Folds one pixel-pair word into the row and column hashes. The frame's
   // last word closes the frame and queues the expected dirty box.
   task automatic fold_word(input logic [WORD_W-1:0] word);
      int unsigned       np, nh, x, y;
      logic [WORD_W-1:0] ch;
      box_type           b;
      np = pairs_in_row();
      nh = rows_in_frame();
      if (col_at >= np || row_at >= nh) new_frame();
      x = col_at;
      y = row_at;
      row_acc = (row_acc ^ word) * HASH_PRIME;
      ch = (y == 0) ? HASH_OFFSET : col_acc[x];
      ch = (ch ^ word) * HASH_PRIME;
      col_acc[x] = ch;
      // Column-pair hashes are only complete in the last row.
      if (y == nh - 1) begin
         if (!seen_frame || ch != pair_memory[x]) begin
            if (!col_dirty) col_lo = x;
            col_hi    = x;
            col_dirty = 1'b1;
         end
         pair_memory[x] = ch;
      end
      if (x != np - 1) begin
         col_at = x + 1;
      end else begin
         if (!seen_frame || row_acc != row_memory[y]) begin
            if (!row_dirty) row_lo = y;
            row_hi    = y;
            row_dirty = 1'b1;
         end
         row_memory[y] = row_acc;
         row_acc = HASH_OFFSET;
         col_at  = 0;
         if (y != nh - 1) begin
            row_at = y + 1;
         end else begin
            b = '0;
            if (row_dirty && col_dirty) begin
               b.x = BOX_XY_W'(2 * col_lo);
               b.y = BOX_XY_W'(row_lo);
               b.w = BOX_WH_W'(2 * (col_hi - col_lo + 1));
               b.h = BOX_WH_W'(row_hi - row_lo + 1);
            end
            expected_boxes.push_back(b);
            seen_frame = 1'b1;
            new_frame();
         end
      end
   endtask

   task automatic check_field(input string field, input logic [BOX_WH_W-1:0] want,
                              input logic [BOX_WH_W-1:0] got);
      if (got !== want) begin
         $display("%0t: box %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_total++;
      end
   endtask

   always @(posedge clock) begin : watch
      box_type want;
      if (reset) begin
         width_reg  = 8'd128;
         height_reg = 9'd256;
         seen_frame = 1'b0;
         for (int i = 0; i < MAX_DIM; i++) row_memory[i] = '0;
         for (int i = 0; i < PAIR_DEPTH; i++) begin
            pair_memory[i] = '0;
            col_acc[i]     = '0;
         end
         new_frame();
         expected_boxes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_boxes.size() == 0) begin
               $display("%0t: unexpected box, expected none, actual x=%0d y=%0d w=%0d h=%0d",
                        $time, rsp_box_x, rsp_box_y, rsp_box_w, rsp_box_h);
               fail_total++;
            end else begin
               want = expected_boxes.pop_front();
               check_field("x", BOX_WH_W'(want.x), BOX_WH_W'(rsp_box_x));
               check_field("y", BOX_WH_W'(want.y), BOX_WH_W'(rsp_box_y));
               check_field("w", want.w, rsp_box_w);
               check_field("h", want.h, rsp_box_h);
               checked_total++;
            end
         end
         // A write to either size register restarts the frame but keeps the history.
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_WIDTH_PAIRS) begin
               width_reg = csr_data[7:0];
               new_frame();
            end else if (csr_index == CSR_FRAME_HEIGHT) begin
               height_reg = csr_data;
               new_frame();
            end
         end
         if (req_valid && req_ready) begin
            if (req_op == OP_FORGET) begin
               seen_frame = 1'b0;
               new_frame();
            end else begin
               fold_word(req_pixel_pair);
            end
         end
      end
      boxes_pending  <= expected_boxes.size();
      mismatch_count <= fail_total;
      boxes_checked  <= checked_total;
   end

endmodule

`default_nettype wire

// ===== bench/tb_frame_dirty_box_hash_tracker.sv =====
// Testbench top for the frame dirty-box hash tracker: clock, reset, stimulus,
// result-side back-pressure and the verdict. Depends on fdbh_pkg, the block
// frame_dirty_box_hash_tracker and the port checker fdbh_checker.
`default_nettype none

module tb_frame_dirty_box_hash_tracker;
   timeunit 1ns;
   timeprecision 1ps;
   import fdbh_pkg::*;

   localparam int MAX_DIM     = 256;
   localparam int ITEM_GOAL   = 1250;
   localparam int CYCLE_LIMIT = 1_000_000;
   // Settle time that lets words that produce no box leave the pipeline.
   localparam int SETTLE      = 8;
   localparam int HOLD_CYCLES = 300;

   logic                   clock;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic                   req_op         = OP_PIXEL;
   logic [WORD_W-1:0]      req_pixel_pair = '0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic [BOX_XY_W-1:0]    rsp_box_x;
   logic [BOX_XY_W-1:0]    rsp_box_y;
   logic [BOX_WH_W-1:0]    rsp_box_w;
   logic [BOX_WH_W-1:0]    rsp_box_h;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = CSR_WIDTH_PAIRS;
   logic [CSR_DATA_W-1:0]  csr_data       = '0;

   int mismatch_count;
   int boxes_pending;
   int boxes_checked;

   // The picture the stimulus streams out; each frame is this scene with a
   // few random edits, so most frames differ from the previous one only a bit.
   logic [WORD_W-1:0] scene [MAX_DIM][MAX_DIM/2];

   // Frame size the block is currently using, after zero and clamp handling.
   int cur_np = MAX_DIM / 2;
   int cur_nh = MAX_DIM;

   int items_sent;
   int forgets_sent;
   int frames_sent;
   int csr_writes;

   // Shared knobs between the request process and the response process.
   bit sender_burst;
   bit receiver_open;
   bit hold_request;

   frame_dirty_box_hash_tracker #(.MAX_DIM(MAX_DIM)) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_pixel_pair (req_pixel_pair),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_box_x      (rsp_box_x),
      .rsp_box_y      (rsp_box_y),
      .rsp_box_w      (rsp_box_w),
      .rsp_box_h      (rsp_box_h),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   fdbh_checker #(.MAX_DIM(MAX_DIM)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_pixel_pair (req_pixel_pair),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_box_x      (rsp_box_x),
      .rsp_box_y      (rsp_box_y),
      .rsp_box_w      (rsp_box_w),
      .rsp_box_h      (rsp_box_h),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .boxes_pending  (boxes_pending),
      .boxes_checked  (boxes_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Idle gaps: mostly none, often short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // A zero register value means one, and anything above the store depth is
   // clamped to it.
   function automatic int clamp_dim(input int raw, input int top);
      if (raw == 0) return 1;
      if (raw > top) return top;
      return raw;
   endfunction

   // Offers one request transaction and returns at the edge where it is taken.
   // Valid stays high afterwards so that the next transaction can follow
   // back to back without lowering and raising it in the same time step.
   task automatic send_item(input logic op, input logic [WORD_W-1:0] word);
      int gap;
      gap = sender_burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_pixel_pair <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (op == OP_FORGET) forgets_sent++;
   endtask

   // Streams the first count words of the scene in raster order. A count
   // short of the full frame leaves a partial frame behind.
   task automatic send_frame(input int count);
      for (int k = 0; k < count; k++) begin
         send_item(OP_PIXEL, scene[k / cur_np][k % cur_np]);
      end
      if (count == cur_np * cur_nh) frames_sent++;
   endtask

   // Lets the block go idle: stop offering, wait for every predicted box to be
   // taken, then give the pipeline time to finish words that produce no box.
   // The first edge lets the checker's count catch up with the last transaction.
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (boxes_pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_writes++;
   endtask

   // Writes both size registers while the block is idle, in random order and
   // sometimes next to a write to an unused index. A change of the effective
   // size must be followed by a forget, since the stored hashes no longer fit.
   task automatic set_geometry(input logic [CSR_DATA_W-1:0] raw_w,
                               input logic [CSR_DATA_W-1:0] raw_h);
      int np, nh;
      quiesce();
      if ($urandom_range(0, 9) == 0) begin
         csr_write(CSR_INDEX_W'($urandom_range(CSR_FRAME_HEIGHT + 1, (1 << CSR_INDEX_W) - 1)),
                   CSR_DATA_W'($urandom_range(0, (1 << CSR_DATA_W) - 1)));
      end
      if ($urandom_range(0, 1) == 1) begin
         csr_write(CSR_WIDTH_PAIRS, raw_w);
         csr_write(CSR_FRAME_HEIGHT, raw_h);
      end else begin
         csr_write(CSR_FRAME_HEIGHT, raw_h);
         csr_write(CSR_WIDTH_PAIRS, raw_w);
      end
      csr_valid <= 1'b0;
      np = clamp_dim(int'(raw_w[7:0]), MAX_DIM / 2);
      nh = clamp_dim(int'(raw_h), MAX_DIM);
      if (np != cur_np || nh != cur_nh) send_item(OP_FORGET, $urandom());
      cur_np = np;
      cur_nh = nh;
   endtask

   // Edits the scene between frames so that the dirty box lands anywhere,
   // from nothing at all to the whole frame.
   task automatic touch_scene();
      int r, x0, x1, y0, y1;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         // Leave the scene alone: the block must report an empty box.
      end else if (r < 65) begin
         x0 = $urandom_range(0, cur_np - 1);
         x1 = $urandom_range(x0, cur_np - 1);
         y0 = $urandom_range(0, cur_nh - 1);
         y1 = $urandom_range(y0, cur_nh - 1);
         for (int y = y0; y <= y1; y++) begin
            for (int x = x0; x <= x1; x++) scene[y][x] = $urandom();
         end
      end else if (r < 80) begin
         x0 = $urandom_range(0, cur_np - 1);
         y0 = $urandom_range(0, cur_nh - 1);
         scene[y0][x0] ^= 32'h1 << $urandom_range(0, 31);
      end else if (r < 90) begin
         x0 = $urandom_range(0, cur_np - 1);
         y0 = $urandom_range(0, cur_nh - 1);
         scene[y0][x0] = ($urandom_range(0, 1) == 1) ? '1 : '0;
      end else begin
         for (int y = 0; y < cur_nh; y++) begin
            for (int x = 0; x < cur_np; x++) scene[y][x] = $urandom();
         end
      end
   endtask

   // Result side: random stalls, open stretches, and on request one long
   // hold-off counted here so that the result queue fills and the input stalls.
   initial begin : receiver
      int   stall_left;
      int   open_left;
      logic ready_next;
      stall_left = 0;
      open_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if (receiver_open || open_left > 0) begin
            if (open_left > 0) open_left--;
            ready_next = 1'b1;
         end else begin
            open_left  = $urandom_range(0, 20);
            stall_left = pick_gap();
            ready_next = (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
         rsp_ready <= ready_next;
      end
   end

   // Watchdog: a correct run finishes far inside this many cycles.
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles with %0d boxes still outstanding.",
               CYCLE_LIMIT, boxes_pending);
      $display("FAIL frame_dirty_box_hash_tracker");
      $finish;
   end

   initial begin : stimulus
      int                    phase;
      int                    frames;
      int                    total;
      int                    r;
      logic [CSR_DATA_W-1:0] raw_w;
      logic [CSR_DATA_W-1:0] raw_h;
      logic [CSR_DATA_W-1:0] prev_w;
      logic [CSR_DATA_W-1:0] prev_h;
      logic [WORD_W-1:0]     word;

      for (int y = 0; y < MAX_DIM; y++) begin
         for (int x = 0; x < MAX_DIM / 2; x++) scene[y][x] = $urandom();
      end
      sender_burst  = 1'b0;
      receiver_open = 1'b0;
      hold_request  = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part on a 2x2 frame. The first frame after a forget is all
      // dirty, an identical frame gives an empty box, and single-word edits
      // give one-pair boxes in the bottom-right and top-left corners.
      set_geometry(9'd2, 9'd2);
      scene[0][0] = 32'h0000_0000;
      scene[0][1] = 32'hFFFF_FFFF;
      scene[1][0] = 32'h1234_5678;
      scene[1][1] = 32'h8000_0001;
      send_frame(4);
      send_frame(4);
      scene[1][1] ^= 32'h0001_0000;
      send_frame(4);
      scene[0][0] = 32'hFFFF_0000;
      send_frame(4);
      // A forget in mid-frame drops the partial frame and the history, so
      // the next whole frame is all dirty again.
      send_frame(2);
      send_item(OP_FORGET, 32'hFFFF_FFFF);
      send_frame(4);

      // Back-pressure: 1x1 frames give a box per word while the receiver
      // holds off for a long stretch, so the block must stall its input.
      set_geometry(9'd1, 9'd1);
      sender_burst = 1'b1;
      hold_request = 1'b1;
      word = $urandom();
      for (int k = 0; k < 16; k++) begin
         if (k % 3 != 0) word = $urandom();
         send_item(OP_PIXEL, word);
      end
      sender_burst = 1'b0;

      // Random part: phases of one frame size each, most small. Two phases
      // use the largest sizes, reached through masked and clamped values.
      prev_w = 9'd1;
      prev_h = 9'd1;
      phase  = 0;
      while (items_sent < ITEM_GOAL || phase < 6) begin
         sender_burst  = ($urandom_range(0, 4) == 0);
         receiver_open = ($urandom_range(0, 3) == 0);
         if (phase == 2) begin
            // All ones in the width register masks to 255 and clamps to the
            // widest row; the second frame dirties only the right-most pair.
            set_geometry(9'h1FF, 9'd1);
            send_frame(cur_np * cur_nh);
            scene[0][cur_np - 1] ^= 32'h1 << $urandom_range(0, 31);
            send_frame(cur_np * cur_nh);
         end else if (phase == 5) begin
            // Bit 8 of the width write is dropped, leaving zero, which means
            // one pair; all ones in the height register clamps to full height.
            set_geometry(9'h100, 9'h1FF);
            send_frame(cur_np * cur_nh);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 80) raw_w = CSR_DATA_W'($urandom_range(1, 8));
            else if (r < 87) raw_w = 9'd0;
            else if (r < 93) raw_w = CSR_DATA_W'(9'h100 | $urandom_range(0, 6));
            else raw_w = CSR_DATA_W'($urandom_range(9, 16));
            r = $urandom_range(0, 99);
            if (r < 85) raw_h = CSR_DATA_W'($urandom_range(1, 8));
            else if (r < 93) raw_h = 9'd0;
            else raw_h = CSR_DATA_W'($urandom_range(9, 12));
            // Sometimes rewrite the current size: the frame restarts but the
            // history survives, so an unchanged scene still reads as clean.
            if ($urandom_range(0, 4) == 0 && cur_np * cur_nh <= 64) begin
               raw_w = prev_w;
               raw_h = prev_h;
            end
            set_geometry(raw_w, raw_h);
            prev_w = raw_w;
            prev_h = raw_h;
            total  = cur_np * cur_nh;
            frames = $urandom_range(3, 8);
            for (int f = 0; f < frames; f++) begin
               if ($urandom_range(0, 19) == 0) send_item(OP_FORGET, $urandom());
               if (total > 1 && $urandom_range(0, 11) == 0) begin
                  send_frame($urandom_range(1, total - 1));
                  send_item(OP_FORGET, $urandom());
               end
               touch_scene();
               send_frame(total);
            end
            // A dangling partial frame is dropped by the next register write.
            if (total > 1 && $urandom_range(0, 3) == 0) send_frame($urandom_range(1, total - 1));
         end
         phase++;
      end

      // Drain: every predicted box must come out, then nothing else may.
      sender_burst  = 1'b0;
      receiver_open = 1'b1;
      quiesce();
      repeat (16) @(posedge clock);
      $display("Covered %0d request transactions (%0d forgets), %0d whole frames, %0d register writes.",
               items_sent, forgets_sent, frames_sent, csr_writes);
      $display("Checked %0d dirty boxes on frames from 1x1 up to 128 pairs wide and 256 rows tall.",
               boxes_checked);
      if (mismatch_count == 0 && boxes_pending == 0) begin
         $display("PASS frame_dirty_box_hash_tracker");
      end else begin
         $display("FAIL frame_dirty_box_hash_tracker");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/fdbh_pkg.sv
hw/rtl/frame_dirty_box_hash_tracker.sv
hw/rtl/fdbh_checker.sv
bench/fdbh_checker.sv
bench/tb_frame_dirty_box_hash_tracker.sv
